FILE: design/gww_pkg.sv
`default_nettype none
package gww_pkg;

	// Character and configuration widths
	localparam int CHAR_W  = 8;
	localparam int CFG_W   = 6;
	localparam int CFG_IDX_W = 1;

	// Special characters
	localparam logic [CHAR_W-1:0] CH_NL  = 8'd10;
	localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
	localparam logic [CHAR_W-1:0] CH_SP  = 8'd32;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_MAX_ROW = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_TAB     = 1'b1;

	// Register reset values
	localparam logic [CFG_W-1:0] MAX_ROW_RST = 6'd32;
	localparam logic [CFG_W-1:0] TAB_RST     = 6'd4;

	// Control shared by every cell of the row
	typedef struct packed {
		logic              shift;
		logic [CHAR_W-1:0] wdata;
	} cell_ctl_t;

endpackage
`default_nettype wire

FILE: design/gww_cell.sv
`default_nettype none
module gww_cell (
	input  wire logic                       clk,
	input  wire gww_pkg::cell_ctl_t         ctl,
	input  wire logic                       wr,
	input  wire logic [gww_pkg::CHAR_W-1:0] nbr,
	output logic      [gww_pkg::CHAR_W-1:0] data
);

	// Take the neighbor's character on a shift, else load on a write
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			data <= nbr;
		end else if (wr) begin
			data <= ctl.wdata;
		end
	end

endmodule
`default_nettype wire

FILE: design/gww_chain.sv
`default_nettype none
module gww_chain #(
	parameter int ROW_CHARS = 32,
	parameter int CW = 6
) (
	input  wire logic                       clk,
	input  wire gww_pkg::cell_ctl_t         ctl,
	input  wire logic                       push,
	input  wire logic [CW-1:0]              push_lo,
	input  wire logic [CW-1:0]              push_n,
	output logic      [gww_pkg::CHAR_W-1:0] head
);

	logic [gww_pkg::CHAR_W-1:0] data [ROW_CHARS];
	logic [ROW_CHARS-1:0]       wr;

	// Build the row; each cell shifts toward the head
	for (genvar i = 0; i < ROW_CHARS; i++) begin : g_cell
		logic [gww_pkg::CHAR_W-1:0] nbr;

		// Write a cell that falls inside the pushed span
		assign wr[i] = push && (i >= int'(push_lo)) && (i < int'(push_lo) + int'(push_n));

		if (i == ROW_CHARS - 1) begin : g_tail
			assign nbr = '0;
		end else begin : g_mid
			assign nbr = data[i+1];
		end

		gww_cell u_cell (
			.clk  (clk),
			.ctl  (ctl),
			.wr   (wr[i]),
			.nbr  (nbr),
			.data (data[i])
		);
	end

	assign head = data[0];

endmodule
`default_nettype wire

FILE: design/greedy_word_wrap_line_breaker_top.sv
`default_nettype none
// Greedy word wrap line breaker.
// Input channel: char_code/text_end with char_valid, stalled by char_stall.
// Output channel: out_char/has_char/line_end/done_res with res_valid, stalled
// by res_stall. Configuration: cfg_we writes cfg_data into register cfg_index
// (0 row width, 1 tab width); write only while the block is idle.
// One transaction is taken at a time. A byte that completes no line is
// decided, then stored into the cell row. A byte that breaks a line is
// decided, then emits its characters (one result for an empty line), then
// drops a break space when there is one, plus the flush of the rest of the line
// when text_end is set. Emission shifts the cell row one character per cycle
// while the output is not stalled, so the row length sets the worst case.
// The first result of a line leaves the output register from the emit state
// that follows the decision. While res_stall is high the output register
// holds its transaction and emission does not advance the row.
// Reset clears the line state and loads the default row width 32 and tab
// width 4; the character row itself needs no clearing.
module greedy_word_wrap_line_breaker_top #(
	parameter int ROW_CHARS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [gww_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [gww_pkg::CFG_W-1:0]     cfg_data,
	input  wire logic                          char_valid,
	output logic                               char_stall,
	input  wire logic [gww_pkg::CHAR_W-1:0]    char_code,
	input  wire logic                          text_end,
	output logic                               res_valid,
	input  wire logic                          res_stall,
	output logic      [gww_pkg::CHAR_W-1:0]    out_char,
	output logic                               has_char,
	output logic                               line_end,
	output logic                               done_res
);

	localparam int CW = $clog2(ROW_CHARS + 1);

	typedef enum logic [1:0] {S_IDLE, S_EMIT, S_POST} state_t;

	state_t                     state_q;
	logic [CW-1:0]              fill_q;
	logic [CW-1:0]              space_pos_q;
	logic                       space_valid_q;
	logic [CW-1:0]              cnt_q;
	logic                       last_q;
	logic                       pend_drop_q;
	logic                       pend_push_q;
	logic                       pend_fin_q;
	logic [gww_pkg::CHAR_W-1:0] push_char_q;
	logic [CW-1:0]              push_cnt_q;
	logic [gww_pkg::CFG_W-1:0]  max_row_q;
	logic [gww_pkg::CFG_W-1:0]  tab_q;

	logic                       accept;
	logic                       out_free;
	logic [CW-1:0]              row_w;
	logic [CW-1:0]              room;
	logic [CW-1:0]              tab_n;
	logic [CW-1:0]              fill_nxt;
	logic                       shift;
	logic                       push;
	logic [gww_pkg::CHAR_W-1:0] head;
	gww_pkg::cell_ctl_t         ctl;

	assign char_stall = (state_q != S_IDLE);
	assign accept     = char_valid && (state_q == S_IDLE);
	assign out_free   = !res_valid || !res_stall;

	// Clamp the row width into one to ROW_CHARS
	always_comb begin
		if (max_row_q == '0) begin
			row_w = CW'(1);
		end else if (int'(max_row_q) > ROW_CHARS) begin
			row_w = CW'(ROW_CHARS);
		end else begin
			row_w = max_row_q[CW-1:0];
		end
	end

	// Clip the tab spaces at the row end
	always_comb begin
		room  = (fill_q < row_w) ? (row_w - fill_q) : '0;
		tab_n = (int'(tab_q) < int'(room)) ? tab_q[CW-1:0] : room;
	end

	// Drive the cell row: shift on emission or drop, store on a push
	always_comb begin
		shift     = ((state_q == S_EMIT) && out_free && (cnt_q != '0))
		            || ((state_q == S_POST) && pend_drop_q);
		push      = (state_q == S_POST) && !pend_drop_q && pend_push_q;
		ctl.shift = shift;
		ctl.wdata = push_char_q;
		fill_nxt  = push ? (fill_q + push_cnt_q) : fill_q;
	end

	gww_chain #(
		.ROW_CHARS (ROW_CHARS),
		.CW        (CW)
	) u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.push    (push),
		.push_lo (fill_q),
		.push_n  (push_cnt_q),
		.head    (head)
	);

	// Sequence decisions, emission and storing; hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			fill_q        <= '0;
			space_pos_q   <= '0;
			space_valid_q <= 1'b0;
			cnt_q         <= '0;
			last_q        <= 1'b0;
			pend_drop_q   <= 1'b0;
			pend_push_q   <= 1'b0;
			pend_fin_q    <= 1'b0;
			max_row_q     <= gww_pkg::MAX_ROW_RST;
			tab_q         <= gww_pkg::TAB_RST;
			res_valid     <= 1'b0;
		end else begin
			// Take register writes
			if (cfg_we) begin
				case (cfg_index)
					gww_pkg::REG_MAX_ROW: max_row_q <= cfg_data;
					gww_pkg::REG_TAB:     tab_q     <= cfg_data;
					default:              ;
				endcase
			end

			// Drop the output transaction once taken
			if (!res_stall) begin
				res_valid <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						pend_fin_q  <= text_end;
						pend_drop_q <= 1'b0;
						pend_push_q <= 1'b0;
						push_cnt_q  <= CW'(1);
						push_char_q <= char_code;
						last_q      <= 1'b0;
						state_q     <= S_POST;
						if (char_code == gww_pkg::CH_NL) begin
							cnt_q         <= fill_q;
							space_valid_q <= 1'b0;
							state_q       <= S_EMIT;
						end else if (char_code == gww_pkg::CH_TAB) begin
							pend_push_q <= 1'b1;
							push_cnt_q  <= tab_n;
							push_char_q <= gww_pkg::CH_SP;
						end else if (char_code == gww_pkg::CH_SP && fill_q == '0) begin
							// leading space: nothing to store
						end else if (fill_q >= row_w) begin
							space_valid_q <= 1'b0;
							state_q       <= S_EMIT;
							if (char_code == gww_pkg::CH_SP) begin
								cnt_q <= fill_q;
							end else if (space_valid_q && space_pos_q < fill_q) begin
								cnt_q       <= space_pos_q;
								pend_drop_q <= 1'b1;
								pend_push_q <= 1'b1;
							end else begin
								cnt_q       <= fill_q;
								pend_push_q <= 1'b1;
							end
						end else begin
							if (char_code == gww_pkg::CH_SP) begin
								space_pos_q   <= fill_q;
								space_valid_q <= 1'b1;
							end
							pend_push_q <= 1'b1;
						end
					end
				end
				S_EMIT: begin
					if (out_free) begin
						res_valid <= 1'b1;
						if (cnt_q == '0) begin
							out_char <= '0;
							has_char <= 1'b0;
							line_end <= 1'b1;
							done_res <= last_q;
							state_q  <= S_POST;
						end else begin
							out_char <= head;
							has_char <= 1'b1;
							line_end <= (cnt_q == CW'(1));
							done_res <= (cnt_q == CW'(1)) && last_q;
							fill_q   <= fill_q - CW'(1);
							cnt_q    <= cnt_q - CW'(1);
							if (cnt_q == CW'(1)) begin
								state_q <= S_POST;
							end
						end
					end
				end
				S_POST: begin
					if (pend_drop_q) begin
						fill_q      <= fill_q - CW'(1);
						pend_drop_q <= 1'b0;
					end else begin
						fill_q      <= fill_nxt;
						pend_push_q <= 1'b0;
						if (pend_fin_q) begin
							cnt_q         <= fill_nxt;
							last_q        <= 1'b1;
							pend_fin_q    <= 1'b0;
							space_pos_q   <= '0;
							space_valid_q <= 1'b0;
							state_q       <= S_EMIT;
						end else begin
							last_q  <= 1'b0;
							state_q <= S_IDLE;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire
